/* rtl/core/assert_macros.svh */
// Assertion macros used by the byte ring FIFO datapath.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define BFR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/core/bfr_pkg.sv */
// Package of the byte ring FIFO with rollback: widths, codes and the
// structs passed between controller, datapath and output queue. No dependencies.
package bfr_pkg;

  localparam int unsigned DEPTH_DEF     = 256;
  localparam int unsigned MAX_READ_DEF  = 64;
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned LEN_W         = 9;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned CNT_W         = 9;
  localparam int unsigned RD_CNT_W      = 7;
  localparam int unsigned RING_SIZE_RST = 256;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE    = 2'd0,
    REQ_READ     = 2'd1,
    REQ_FLUSH    = 2'd2,
    REQ_ROLLBACK = 2'd3
  } bfr_req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_LONG  = 3'd4
  } bfr_status_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [LEN_W-1:0]  burst_length;
    logic [BYTE_W-1:0] data_byte;
  } bfr_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   read_byte;
    logic                last;
    logic [CNT_W-1:0]    fill_level;
  } bfr_res_t;

  typedef struct packed {
    logic accept;
    logic issue;
  } bfr_cmd_t;

  typedef struct packed {
    logic read_start;
    logic inflight;
    logic rd_last;
  } bfr_dp_st_t;

  typedef struct packed {
    logic [1:0] level;
    logic       pop;
  } bfr_q_st_t;

endpackage

/* rtl/core/bfr_req_if.sv */
// Request channel of the byte ring FIFO: valid, ready and the request fields.
// Depends on bfr_pkg for the field widths.
interface bfr_req_if;
  logic                         valid;
  logic                         ready;
  logic [bfr_pkg::REQ_W-1:0]    req_type;
  logic [bfr_pkg::LEN_W-1:0]    burst_length;
  logic [bfr_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, req_type, burst_length, data_byte, input ready);
  modport sink   (input valid, req_type, burst_length, data_byte, output ready);
endinterface

/* rtl/core/bfr_res_if.sv */
// Result channel of the byte ring FIFO: valid, ready and the result fields.
// Depends on bfr_pkg for the field widths.
interface bfr_res_if;
  logic                          valid;
  logic                          ready;
  logic [bfr_pkg::STATUS_W-1:0]  status;
  logic [bfr_pkg::BYTE_W-1:0]    read_byte;
  logic                          last;
  logic [bfr_pkg::CNT_W-1:0]     fill_level;

  modport source (output valid, status, read_byte, last, fill_level, input ready);
  modport sink   (input valid, status, read_byte, last, fill_level, output ready);
endinterface

/* rtl/core/bfr_datapath.sv */
// Datapath of the byte ring FIFO: byte memory, ring pointers, counters,
// burst tracking and result formation. Depends on bfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bfr_datapath #(
  parameter int unsigned DEPTH    = bfr_pkg::DEPTH_DEF,
  parameter int unsigned MAX_READ = bfr_pkg::MAX_READ_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bfr_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  bfr_pkg::bfr_item_t         item_i,
  input  bfr_pkg::bfr_cmd_t          cmd_i,
  output bfr_pkg::bfr_dp_st_t        st_o,
  output logic                       res_valid_o,
  output bfr_pkg::bfr_res_t          res_o
);

  localparam int unsigned MemDepth = (DEPTH > 512) ? 512 : DEPTH;
  localparam int unsigned IdxW     = $clog2(MemDepth);
  localparam int unsigned EffReset = (MemDepth < bfr_pkg::RING_SIZE_RST) ?
                                     MemDepth : bfr_pkg::RING_SIZE_RST;
  localparam int unsigned CW       = bfr_pkg::CNT_W;
  localparam int unsigned RW       = bfr_pkg::RD_CNT_W;

  logic [bfr_pkg::BYTE_W-1:0] mem [MemDepth];

  logic [CW-1:0]   eff_q, eff_d;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   brem_q, brem_d;
  logic            bdrop_q, bdrop_d;
  logic [RW-1:0]   rd_cnt_q, rd_cnt_d;
  logic            inflight_q, inflight_d;
  logic            rd_last_q, rd_last_d;
  logic [CW-1:0]   rd_fill_q, rd_fill_d;
  logic [bfr_pkg::BYTE_W-1:0] rd_data_q;

  logic            mem_we;
  logic            read_start;
  logic [CW:0]     cfg_eff;
  logic            first;
  logic            dropped;
  logic [CW-1:0]   rem;
  logic [CW-1:0]   rem_n;
  bfr_pkg::bfr_res_t single;

  function automatic logic [IdxW-1:0] adv(input logic [IdxW-1:0] idx,
                                          input logic [CW-1:0] eff);
    logic [CW:0] n;
    n = (CW+1)'(idx) + (CW+1)'(1);
    adv = (n >= {1'b0, eff}) ? '0 : IdxW'(n);
  endfunction

  assign read_start = (item_i.req_type == bfr_pkg::REQ_READ) &&
                      (item_i.burst_length != '0) &&
                      (item_i.burst_length <= CW'(MAX_READ)) &&
                      (item_i.burst_length <= count_q);

  always_comb begin
    eff_d      = eff_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    brem_d     = brem_q;
    bdrop_d    = bdrop_q;
    rd_cnt_d   = rd_cnt_q;
    inflight_d = 1'b0;
    rd_last_d  = rd_last_q;
    rd_fill_d  = rd_fill_q;
    mem_we     = 1'b0;
    first      = (brem_q == '0);
    rem        = first ? item_i.burst_length : brem_q;
    dropped    = first ? (item_i.burst_length > (eff_q - count_q)) : bdrop_q;
    rem_n      = rem - CW'(1);
    cfg_eff    = (cfg_wdata_i == '0) ? (CW+1)'(1) : {1'b0, cfg_wdata_i};
    if (cfg_eff > (CW+1)'(MemDepth)) begin
      cfg_eff = (CW+1)'(MemDepth);
    end
    single.status    = bfr_pkg::ST_OK;
    single.read_byte = '0;
    single.last      = 1'b1;

    if (cfg_we_i) begin
      eff_d   = cfg_eff[CW-1:0];
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
      brem_d  = '0;
      bdrop_d = 1'b0;
    end else if (cmd_i.accept) begin
      case (bfr_pkg::bfr_req_e'(item_i.req_type))
        bfr_pkg::REQ_WRITE: begin
          if (first && (item_i.burst_length == '0)) begin
            single.status = bfr_pkg::ST_OK;
          end else begin
            if (!dropped && (count_q < eff_q)) begin
              mem_we  = 1'b1;
              tail_d  = adv(tail_q, eff_q);
              count_d = count_q + CW'(1);
            end
            brem_d        = rem_n;
            bdrop_d       = (rem_n == '0) ? 1'b0 : dropped;
            single.status = dropped ? bfr_pkg::ST_OVERFLOW : bfr_pkg::ST_OK;
            single.last   = (rem_n == '0);
          end
        end
        bfr_pkg::REQ_READ: begin
          if (item_i.burst_length == '0) begin
            single.status = bfr_pkg::ST_OK;
          end else if (item_i.burst_length > CW'(MAX_READ)) begin
            single.status = bfr_pkg::ST_TOO_LONG;
          end else if (item_i.burst_length > count_q) begin
            single.status = bfr_pkg::ST_UNDERFLOW;
          end else begin
            rd_cnt_d = item_i.burst_length[RW-1:0];
          end
        end
        bfr_pkg::REQ_FLUSH: begin
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
          brem_d  = '0;
          bdrop_d = 1'b0;
        end
        bfr_pkg::REQ_ROLLBACK: begin
          if (count_q == '0) begin
            single.status = bfr_pkg::ST_EMPTY;
          end else begin
            tail_d  = (tail_q == '0) ? IdxW'(eff_q - CW'(1)) : tail_q - IdxW'(1);
            count_d = count_q - CW'(1);
          end
        end
        default: begin
          single.status = bfr_pkg::ST_OK;
        end
      endcase
    end else if (cmd_i.issue) begin
      head_d     = adv(head_q, eff_q);
      count_d    = count_q - CW'(1);
      rd_cnt_d   = rd_cnt_q - RW'(1);
      inflight_d = 1'b1;
      rd_last_d  = (rd_cnt_q == RW'(1));
      rd_fill_d  = count_q - CW'(1);
    end
    single.fill_level = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q      <= CW'(EffReset);
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      brem_q     <= '0;
      bdrop_q    <= 1'b0;
      rd_cnt_q   <= '0;
      inflight_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      eff_q      <= eff_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      brem_q     <= brem_d;
      bdrop_q    <= bdrop_d;
      rd_cnt_q   <= rd_cnt_d;
      inflight_q <= inflight_d;
      rd_last_q  <= rd_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_fill_q <= rd_fill_d;
    if (mem_we) begin
      mem[tail_q] <= item_i.data_byte;
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem[head_q];
    end
  end

  assign st_o.read_start = read_start;
  assign st_o.inflight   = inflight_q;
  assign st_o.rd_last    = (rd_cnt_q == RW'(1));

  assign res_valid_o = inflight_q || (cmd_i.accept && !read_start);

  always_comb begin
    if (inflight_q) begin
      res_o.status     = bfr_pkg::ST_OK;
      res_o.read_byte  = rd_data_q;
      res_o.last       = rd_last_q;
      res_o.fill_level = rd_fill_q;
    end else begin
      res_o = single;
    end
  end

  `BFR_ASSERT(a_count_within_size, count_q <= eff_q, "stored count exceeds ring size")
  `BFR_ASSERT(a_inflight_after_issue, inflight_q |-> $past(cmd_i.issue), "read byte without issue")
  `BFR_ASSERT_NEVER(a_accept_during_read, cmd_i.accept && inflight_q, "request taken during read")

endmodule

/* rtl/core/bfr_out_queue.sv */
// Two-entry result queue that decouples result delivery from request intake.
// Depends on bfr_pkg and the bfr_res_if interface.
module bfr_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bfr_pkg::bfr_res_t  data_i,
  output bfr_pkg::bfr_q_st_t st_o,
  bfr_res_if.source          res_o
);

  bfr_pkg::bfr_res_t ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] level_q;
  logic       pop;

  assign pop = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      level_q <= level_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= data_i;
    end
  end

  assign res_o.valid      = (level_q != '0);
  assign res_o.status     = ent_q[rptr_q].status;
  assign res_o.read_byte  = ent_q[rptr_q].read_byte;
  assign res_o.last       = ent_q[rptr_q].last;
  assign res_o.fill_level = ent_q[rptr_q].fill_level;

  assign st_o.level = level_q;
  assign st_o.pop   = pop;

endmodule

/* rtl/core/bfr_ctrl.sv */
// Controller of the byte ring FIFO: request intake and read burst sequencing.
// Depends on bfr_pkg for the command and status structs.
module bfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  bfr_pkg::bfr_dp_st_t dp_st_i,
  input  bfr_pkg::bfr_q_st_t  q_st_i,
  output logic                req_ready_o,
  output bfr_pkg::bfr_cmd_t   cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] occ;

  always_comb begin
    occ = {1'b0, q_st_i.level} + {2'b0, dp_st_i.inflight} - {2'b0, q_st_i.pop};
    req_ready_o  = (state_q == S_IDLE) && !dp_st_i.inflight &&
                   ((q_st_i.level != 2'd2) || q_st_i.pop);
    cmd_o.accept = req_ready_o && req_valid_i;
    cmd_o.issue  = (state_q == S_READ) && (occ < 3'd2);
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && dp_st_i.read_start) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (cmd_o.issue && dp_st_i.rd_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/byte_ring_fifo_with_rollback_top.sv */
// Top level of the byte ring FIFO with rollback: controller, datapath and
// result queue. Depends on bfr_pkg, bfr_req_if, bfr_res_if and the submodules.
//
//   port    direction  fields
//   req_i   in         req_type, burst_length, data_byte
//   res_o   out        status, read_byte, last, fill_level
//   cfg     in         cfg_we_i, cfg_wdata_i (ring_size)
//
// Write, flush, rollback, zero-length and rejected reads each give one result.
// A read burst of N bytes issues one memory read per cycle while the result queue
// has room; each byte reaches res_o through the datapath read register and the queue.
// The next request is taken only after the burst's last byte has left the datapath.
// A two-entry result queue lets the block take requests while results wait.
// Reset is immediate, with no clearing pass.
module byte_ring_fifo_with_rollback_top #(
  parameter int unsigned DEPTH    = bfr_pkg::DEPTH_DEF,
  parameter int unsigned MAX_READ = bfr_pkg::MAX_READ_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bfr_pkg::CNT_W-1:0] cfg_wdata_i,
  bfr_req_if.sink                   req_i,
  bfr_res_if.source                 res_o
);

  bfr_pkg::bfr_item_t  item;
  bfr_pkg::bfr_cmd_t   cmd;
  bfr_pkg::bfr_dp_st_t dp_st;
  bfr_pkg::bfr_q_st_t  q_st;
  bfr_pkg::bfr_res_t   res;
  logic                res_valid;
  logic                req_ready;

  assign item.req_type     = req_i.req_type;
  assign item.burst_length = req_i.burst_length;
  assign item.data_byte    = req_i.data_byte;
  assign req_i.ready       = req_ready;

  bfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .dp_st_i     (dp_st),
    .q_st_i      (q_st),
    .req_ready_o (req_ready),
    .cmd_o       (cmd)
  );

  bfr_datapath #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .st_o        (dp_st),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bfr_out_queue u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .st_o   (q_st),
    .res_o  (res_o)
  );

endmodule

/* dv/byte_ring_fifo_with_rollback_checker.sv */
// Checker for the byte ring FIFO: watches the request, result and ring size ports,
// predicts each result and compares it field by field.
// Depends on bfr_pkg, bfr_req_if and bfr_res_if.
module byte_ring_fifo_with_rollback_checker
  import bfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  bfr_req_if               req_i,
  bfr_res_if               res_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      fill_o,
  output int unsigned      checked_o
);

  logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
  int unsigned       head_q;
  int unsigned       tail_q;
  int unsigned       count_q;
  int unsigned       burst_left;
  bit                burst_drop;
  int unsigned       ring_size_q;
  bfr_res_t          expected_q [$];

  function automatic int unsigned slots();
    if (ring_size_q == 0) return 1;
    if (ring_size_q > DEPTH_DEF) return DEPTH_DEF;
    return ring_size_q;
  endfunction

  function automatic int unsigned next_slot(int unsigned idx);
    return (idx + 1 >= slots()) ? 0 : idx + 1;
  endfunction

  function void empty_ring();
    head_q     = 0;
    tail_q     = 0;
    count_q    = 0;
    burst_left = 0;
    burst_drop = 0;
  endfunction

  function void queue_result(bfr_status_e st, logic [BYTE_W-1:0] rd, logic lst);
    bfr_res_t r;
    r.status     = st;
    r.read_byte  = rd;
    r.last       = lst;
    r.fill_level = CNT_W'(count_q);
    expected_q.push_back(r);
  endfunction

  function void predict_request(logic [REQ_W-1:0] kind, logic [LEN_W-1:0] len,
                                logic [BYTE_W-1:0] data);
    int unsigned       n;
    int unsigned       i;
    logic [BYTE_W-1:0] rd;
    bfr_status_e       st;
    n = len;
    case (bfr_req_e'(kind))
      REQ_WRITE: begin
        if (burst_left == 0 && n == 0) begin
          queue_result(ST_OK, '0, 1'b1);
        end else begin
          if (burst_left == 0) begin
            burst_drop = n > slots() - count_q;
            burst_left = n;
          end
          if (burst_drop) begin
            st = ST_OVERFLOW;
          end else begin
            st = ST_OK;
            if (count_q < slots()) begin
              ring_mem[tail_q] = data;
              tail_q = next_slot(tail_q);
              count_q++;
            end
          end
          burst_left--;
          if (burst_left == 0) burst_drop = 0;
          queue_result(st, '0, burst_left == 0);
        end
      end
      REQ_READ: begin
        if (n == 0) begin
          queue_result(ST_OK, '0, 1'b1);
        end else if (n > MAX_READ_DEF) begin
          queue_result(ST_TOO_LONG, '0, 1'b1);
        end else if (n > count_q) begin
          queue_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          for (i = 0; i < n; i++) begin
            rd = ring_mem[head_q];
            head_q = next_slot(head_q);
            count_q--;
            queue_result(ST_OK, rd, i + 1 == n);
          end
        end
      end
      REQ_FLUSH: begin
        empty_ring();
        queue_result(ST_OK, '0, 1'b1);
      end
      default: begin
        if (count_q == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          tail_q = (tail_q == 0) ? slots() - 1 : tail_q - 1;
          count_q--;
          queue_result(ST_OK, '0, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t: result %0d: %s: expected %0d, got %0d", $time, checked_o, what,
             want, got);
    fail_count_o++;
  endtask

  task automatic check_result();
    bfr_res_t exp_r;
    if (expected_q.size() == 0) begin
      report_mismatch("result with no request outstanding, status", 0, res_i.status);
    end else begin
      exp_r = expected_q.pop_front();
      if (res_i.status !== exp_r.status)
        report_mismatch("status", exp_r.status, res_i.status);
      if (res_i.read_byte !== exp_r.read_byte)
        report_mismatch("read_byte", exp_r.read_byte, res_i.read_byte);
      if (res_i.last !== exp_r.last)
        report_mismatch("last", exp_r.last, res_i.last);
      if (res_i.fill_level !== exp_r.fill_level)
        report_mismatch("fill_level", exp_r.fill_level, res_i.fill_level);
    end
    checked_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q = RING_SIZE_RST;
      empty_ring();
      expected_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (res_i.valid && res_i.ready) check_result();
      if (req_i.valid && req_i.ready) begin
        predict_request(req_i.req_type, req_i.burst_length, req_i.data_byte);
      end
      if (cfg_we_i) begin
        ring_size_q = cfg_wdata_i;
        empty_ring();
      end
    end
    pending_o = expected_q.size();
    fill_o    = count_q;
  end

endmodule

/* dv/byte_ring_fifo_with_rollback_top_test.sv */
// Testbench top for the byte ring FIFO: drives requests, ring size writes and
// result backpressure, and gives the verdict from the checker's failure and pending counts.
// Depends on bfr_pkg, the channel interfaces, the block and the checker.
module byte_ring_fifo_with_rollback_top_test;
  import bfr_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  int unsigned      fails;
  int unsigned      pending;
  int unsigned      fill;
  int unsigned      checked;
  int unsigned      n_req;
  int unsigned      n_phases;
  int unsigned      slots;
  bit               no_idle;

  bfr_req_if req_ch ();
  bfr_res_if res_ch ();

  byte_ring_fifo_with_rollback_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  byte_ring_fifo_with_rollback_checker u_ring_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_ch),
    .res_i        (res_ch),
    .fail_count_o (fails),
    .pending_o    (pending),
    .fill_o       (fill),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("byte_ring_fifo_with_rollback_top_test: done, errors");
    $finish;
  end

  function automatic int unsigned pick_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 17);
  endfunction

  initial begin
    int unsigned gap;
    res_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
    end
  end

  task automatic issue_request(bfr_req_e kind, int unsigned len, logic [BYTE_W-1:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.burst_length <= LEN_W'(len);
    req_ch.data_byte    <= data;
    do @(posedge clk_i); while (!req_ch.ready);
    n_req++;
  endtask

  task automatic set_ring(int unsigned v);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(v);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    slots = (v == 0) ? 1 : (v > DEPTH_DEF ? DEPTH_DEF : v);
    n_phases++;
  endtask

  // Inside a burst, reads and rollbacks are mixed in now and then, and a flush
  // occasionally cuts the burst short.
  task automatic write_burst(int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      if (k > 0 && $urandom_range(0, 39) == 0) begin
        issue_request(REQ_FLUSH, $urandom_range(0, 256), $urandom);
        return;
      end
      if (k > 0 && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1)
          issue_request(REQ_ROLLBACK, $urandom_range(0, 256), $urandom);
        else
          issue_request(REQ_READ, (fill == 0) ? 1 : $urandom_range(1, fill < 8 ? fill : 8),
                        $urandom);
      end
      issue_request(REQ_WRITE, (k == 0) ? len : $urandom_range(0, 256), $urandom_range(0, 255));
    end
  endtask

  initial begin
    int unsigned ring_plan [9] = '{256, 1, 2, 7, 0, 300, 64, 129, 256};
    int unsigned p;
    int unsigned r;
    int unsigned len;
    int unsigned free;
    int unsigned phase_end;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_WRITE;
    req_ch.burst_length = '0;
    req_ch.data_byte    = '0;
    n_req               = 0;
    n_phases            = 0;
    slots               = RING_SIZE_RST;
    no_idle             = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_request(REQ_READ, 0, 8'h00);
    issue_request(REQ_WRITE, 0, 8'hFF);
    issue_request(REQ_ROLLBACK, 0, 8'h00);
    issue_request(REQ_READ, 1, 8'h00);
    issue_request(REQ_READ, 65, 8'h00);
    issue_request(REQ_READ, 64, 8'h00);
    issue_request(REQ_WRITE, 3, 8'h00);
    issue_request(REQ_WRITE, 0, 8'hFF);
    issue_request(REQ_WRITE, 256, 8'hA5);
    issue_request(REQ_READ, 256, 8'h00);
    issue_request(REQ_READ, 4, 8'h00);
    issue_request(REQ_ROLLBACK, 0, 8'h00);
    issue_request(REQ_READ, 2, 8'h00);
    issue_request(REQ_WRITE, 2, 8'h5A);
    issue_request(REQ_READ, 1, 8'h00);
    issue_request(REQ_WRITE, 7, 8'hC3);
    issue_request(REQ_WRITE, 256, 8'h22);
    issue_request(REQ_WRITE, 0, 8'h33);
    issue_request(REQ_FLUSH, 0, 8'h00);
    set_ring(3);
    issue_request(REQ_WRITE, 3, 8'h01);
    issue_request(REQ_WRITE, 0, 8'h02);
    issue_request(REQ_WRITE, 0, 8'h03);
    issue_request(REQ_WRITE, 1, 8'h04);
    issue_request(REQ_ROLLBACK, 0, 8'h00);
    issue_request(REQ_READ, 2, 8'h00);
    issue_request(REQ_ROLLBACK, 0, 8'h00);

    for (p = 0; p < 9; p++) begin
      set_ring(ring_plan[p]);
      no_idle = ($urandom_range(0, 3) == 0);
      phase_end = n_req + 20;
      while (n_req < phase_end) begin
        if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
        r = $urandom_range(0, 99);
        free = (fill >= slots) ? 0 : slots - fill;
        if (r < 45) begin
          if (free == 0)
            len = $urandom_range(1, 3);
          else if (free <= 8 && $urandom_range(0, 5) == 0)
            len = free + $urandom_range(1, 3);
          else if (free <= 64 && $urandom_range(0, 7) == 0)
            len = free;
          else
            len = $urandom_range(1, free < 12 ? free : 12);
          write_burst(len);
        end else if (r < 70) begin
          if ($urandom_range(0, 7) == 0)
            len = $urandom_range(0, 256);
          else if (fill == 0)
            len = $urandom_range(0, 2);
          else
            len = $urandom_range(1, fill < MAX_READ_DEF ? fill : MAX_READ_DEF);
          issue_request(REQ_READ, len, $urandom);
        end else if (r < 78) begin
          issue_request(REQ_ROLLBACK, $urandom_range(0, 256), $urandom);
        end else if (r < 83) begin
          issue_request(REQ_FLUSH, $urandom_range(0, 256), $urandom);
        end else if (r < 88) begin
          issue_request(($urandom_range(0, 1) == 1) ? REQ_READ : REQ_WRITE, 0, $urandom);
        end else begin
          r = $urandom_range(0, 3);
          issue_request(bfr_req_e'(r), (r == REQ_WRITE) ? $urandom_range(0, 4)
                                                         : $urandom_range(0, 256), $urandom);
        end
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("Sent %0d requests over %0d ring size settings; %0d results compared.",
             n_req, n_phases, checked);
    if (fails == 0 && pending == 0) begin
      $display("byte_ring_fifo_with_rollback_top_test: done, clean");
    end else begin
      $display("byte_ring_fifo_with_rollback_top_test: done, errors");
    end
    $finish;
  end

endmodule
